>>> rtl/cca_pkg.sv
package cca_pkg;

    // pool geometry
    localparam int NUM_CHUNKS = 256;
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int NUM_GROUPS = (NUM_CHUNKS + LANES - 1) / LANES;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IX_W       = GRP_W + LANE_W;
    localparam int MAP_W      = NUM_GROUPS * LANES;
    localparam int LIM_W      = (IX_W + 1 > 10) ? IX_W + 1 : 10;

    // field widths
    localparam int START_W    = 8;
    localparam int CNT_W      = 9;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 8;
    localparam int OFF_W      = 24;
    localparam int CB_W       = 17;

    localparam logic [CB_W-1:0] CB_RESET = CB_W'(64);

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd4;

    // what the group unit reports about one group of chunks
    typedef struct packed {
        logic             hit;
        logic [IX_W-1:0]  hit_idx;
        logic [CNT_W-1:0] run;
        logic             taken;
    } grp_res_t;

endpackage

>>> rtl/cca_group_unit.sv
module cca_group_unit (
    input  logic [cca_pkg::LANES-1:0] bits,
    input  logic [cca_pkg::GRP_W-1:0] grp,
    input  logic [cca_pkg::LIM_W-1:0] lo,
    input  logic [cca_pkg::LIM_W-1:0] hi,
    input  logic [cca_pkg::CNT_W-1:0] need,
    input  logic [cca_pkg::CNT_W-1:0] run_in,
    input  logic                      fill_val,
    output cca_pkg::grp_res_t         res,
    output logic [cca_pkg::LANES-1:0] new_bits
);

    always_comb begin
        logic [cca_pkg::IX_W-1:0]  idx;
        logic [cca_pkg::CNT_W-1:0] r;
        logic                      in_rng;
        r            = run_in;
        res.hit      = 1'b0;
        res.hit_idx  = '0;
        res.taken    = 1'b0;
        new_bits     = bits;
        for (int j = 0; j < cca_pkg::LANES; j++) begin
            idx    = {grp, cca_pkg::LANE_W'(j)};
            in_rng = (cca_pkg::LIM_W'(idx) >= lo) && (cca_pkg::LIM_W'(idx) < hi);
            // run length chain, frozen once the run is long enough
            if (!res.hit) begin
                r = bits[j] ? r + 1'b1 : '0;
                if (r == need) begin
                    res.hit     = 1'b1;
                    res.hit_idx = idx;
                end
            end
            if (in_rng && bits[j]) begin
                res.taken = 1'b1;
            end
            if (in_rng) begin
                new_bits[j] = fill_val;
            end
        end
        res.run = r;
    end

endmodule

>>> rtl/contiguous_chunk_allocator_core.sv
// Contiguous chunk allocator: a pool of NUM_CHUNKS equal chunks whose free map (one bit a
// chunk, 1 = free) is walked four chunks a cycle by one shared group unit under a small
// sequencer. The pool is empty after reset; chunks must be freed into it before they can be
// allocated. An allocate request takes the lowest-addressed run of count free chunks and
// returns its index and index times chunk_bytes; a free request releases count chunks from
// start_index after checking range and that none is free already. One request is handled at
// a time and s_tready is low while it runs. Zero counts, oversized allocates and out-of-range
// frees go straight to the output state. An allocate scans up to NUM_GROUPS groups (64 at
// 256 chunks), then marks the run group by group; a free checks, then fills the run, group
// by group. The output state moves the result into the output register, which holds it
// until taken while the next request may already be accepted. chunk_bytes is written
// through cfg_we/cfg_wdata only while the block is idle, which the user, not the block, ensures.
module contiguous_chunk_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,      // chunk_bytes
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // start_index[7:0], count[16:8], zero pad
    input  logic [0:0]  s_tuser,        // action
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // run_index[7:0], run_offset[31:8]
    output logic [3:0]  m_tuser         // ok[0], status[3:1]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MARK,
        S_FILL,
        S_OUT
    } state_t;

    state_t                           state_reg;
    logic [cca_pkg::MAP_W-1:0]        free_map_reg;
    logic [cca_pkg::CB_W-1:0]         chunk_bytes_reg;
    logic [cca_pkg::GRP_W-1:0]        grp_reg;
    logic [cca_pkg::CNT_W-1:0]        run_reg;
    logic [cca_pkg::CNT_W-1:0]        n_reg;
    logic [cca_pkg::LIM_W-1:0]        lo_reg;
    logic [cca_pkg::LIM_W-1:0]        hi_reg;
    logic [cca_pkg::IX_W-1:0]         first_reg;
    logic                             res_ok_reg;
    logic [cca_pkg::STATUS_W-1:0]     res_status_reg;

    // output register
    logic                             m_tvalid_reg;
    logic                             m_ok_reg;
    logic [cca_pkg::STATUS_W-1:0]     m_status_reg;
    logic [cca_pkg::IDX_OUT_W-1:0]    m_idx_reg;
    logic [cca_pkg::OFF_W-1:0]        m_off_reg;

    // request fields
    logic                             req_action;
    logic [cca_pkg::START_W-1:0]      req_start;
    logic [cca_pkg::CNT_W-1:0]        req_count;
    logic [cca_pkg::LIM_W-1:0]        req_end;

    assign req_action = s_tuser[0];
    assign req_start  = s_tdata[7:0];
    assign req_count  = s_tdata[16:8];
    assign req_end    = cca_pkg::LIM_W'(req_start) + cca_pkg::LIM_W'(req_count);

    // group walked this cycle
    logic [cca_pkg::LANES-1:0]        grp_bits;
    logic [cca_pkg::LANES-1:0]        grp_new_bits;
    cca_pkg::grp_res_t                gres;
    logic                             last_grp;
    logic [cca_pkg::LIM_W-1:0]        first_calc;
    logic [cca_pkg::IX_W+cca_pkg::CB_W-1:0] offset_full;

    assign grp_bits = free_map_reg[{grp_reg, cca_pkg::LANE_W'(0)} +: cca_pkg::LANES];

    // range walk ends once the next group starts at or past the range end
    assign last_grp = (cca_pkg::LIM_W'({grp_reg, cca_pkg::LANE_W'(0)})
                       + cca_pkg::LIM_W'(cca_pkg::LANES)) >= hi_reg;

    // start of the run that ended at the hit chunk
    assign first_calc = cca_pkg::LIM_W'(gres.hit_idx) + 1'b1 - cca_pkg::LIM_W'(n_reg);

    assign offset_full = {{cca_pkg::CB_W{1'b0}}, first_reg}
                       * {{cca_pkg::IX_W{1'b0}}, chunk_bytes_reg};

    cca_group_unit u_group (
        .bits     (grp_bits),
        .grp      (grp_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .need     (n_reg),
        .run_in   (run_reg),
        .fill_val (state_reg == S_FILL),
        .res      (gres),
        .new_bits (grp_new_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            free_map_reg    <= '0;
            chunk_bytes_reg <= cca_pkg::CB_RESET;
        end else begin
            if (cfg_we) begin
                chunk_bytes_reg <= cfg_wdata;
            end
            // the output register drops its valid once the result is taken, unless a new one is loaded
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        n_reg      <= req_count;
                        run_reg    <= '0;
                        first_reg  <= '0;
                        res_ok_reg <= 1'b0;
                        if (req_count == '0) begin
                            res_status_reg <= cca_pkg::ST_ZERO;
                            lo_reg         <= '0;
                            hi_reg         <= '0;
                            grp_reg        <= '0;
                            state_reg      <= S_OUT;
                        end else if (req_action == cca_pkg::ACT_ALLOC) begin
                            lo_reg  <= '0;
                            hi_reg  <= '0;
                            grp_reg <= '0;
                            // a run longer than the pool can never fit
                            if (cca_pkg::LIM_W'(req_count)
                                > cca_pkg::LIM_W'(cca_pkg::NUM_CHUNKS)) begin
                                res_status_reg <= cca_pkg::ST_NO_RUN;
                                state_reg      <= S_OUT;
                            end else begin
                                res_status_reg <= cca_pkg::ST_OK;
                                state_reg      <= S_SCAN;
                            end
                        end else begin
                            if (req_end > cca_pkg::LIM_W'(cca_pkg::NUM_CHUNKS)) begin
                                res_status_reg <= cca_pkg::ST_RANGE;
                                lo_reg         <= '0;
                                hi_reg         <= '0;
                                grp_reg        <= '0;
                                state_reg      <= S_OUT;
                            end else begin
                                res_status_reg <= cca_pkg::ST_OK;
                                lo_reg    <= cca_pkg::LIM_W'(req_start);
                                hi_reg    <= req_end;
                                grp_reg   <= cca_pkg::GRP_W'(req_start >> cca_pkg::LANE_W);
                                state_reg <= S_CHECK;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    run_reg <= gres.run;
                    if (gres.hit) begin
                        first_reg <= cca_pkg::IX_W'(first_calc);
                        lo_reg    <= first_calc;
                        hi_reg    <= cca_pkg::LIM_W'(gres.hit_idx) + 1'b1;
                        grp_reg   <= first_calc[cca_pkg::LANE_W +: cca_pkg::GRP_W];
                        state_reg <= S_MARK;
                    end else if (grp_reg == cca_pkg::GRP_W'(cca_pkg::NUM_GROUPS - 1)) begin
                        res_status_reg <= cca_pkg::ST_NO_RUN;
                        state_reg      <= S_OUT;
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (gres.taken) begin
                        res_status_reg <= cca_pkg::ST_ALREADY;
                        state_reg      <= S_OUT;
                    end else if (last_grp) begin
                        grp_reg   <= lo_reg[cca_pkg::LANE_W +: cca_pkg::GRP_W];
                        state_reg <= S_FILL;
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                S_MARK, S_FILL: begin
                    free_map_reg[{grp_reg, cca_pkg::LANE_W'(0)} +: cca_pkg::LANES]
                        <= grp_new_bits;
                    if (last_grp) begin
                        res_ok_reg     <= 1'b1;
                        res_status_reg <= cca_pkg::ST_OK;
                        state_reg      <= S_OUT;
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    // wait for the output register to drain
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_ok_reg     <= res_ok_reg;
                        m_status_reg <= res_status_reg;
                        m_idx_reg    <= cca_pkg::IDX_OUT_W'(first_reg);
                        m_off_reg    <= cca_pkg::OFF_W'(offset_full);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_off_reg, m_idx_reg};
    assign m_tuser  = {m_status_reg, m_ok_reg};

`ifndef ASSERT_OFF
    // the free map only changes while a run is being marked or filled
    a_map_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_MARK && state_reg != S_FILL) |=> $stable(free_map_reg))
        else $error("free map changed outside a mark or fill pass");

    // the scan leaves as soon as the run reaches the requested length
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (run_reg < n_reg))
        else $error("run counter reached request length during scan");

    // ok flag agrees with the status code
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_ok_reg == (m_status_reg == cca_pkg::ST_OK)))
        else $error("ok flag and status disagree");

    // failed requests report a zero run index and offset
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_ok_reg) |-> (m_idx_reg == '0 && m_off_reg == '0))
        else $error("failed request carries a nonzero run");
`endif

endmodule
